[rtl/lba_pkg.sv]
// shared types, constants and helpers for the largest blob area block
`default_nettype none

package lba_pkg;

    // grid limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int STK_W    = ROW_W + COL_W;
    localparam int TOP_W    = ADDR_W + 1;

    // register and result widths
    localparam int REG_W  = 7;
    localparam int AREA_W = 13;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    // register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // one cell write from the loader
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             land;
    } load_req_t;

    // search result toward the output stage
    typedef struct packed {
        logic              valid;
        logic [AREA_W-1:0] area;
    } walk_res_t;

    // memory address of a cell, fixed row stride of MAX_COLS
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [ADDR_W+REG_W+ROW_W-1:0] full;
        full = (ADDR_W+REG_W+ROW_W)'(r) * (ADDR_W+REG_W+ROW_W)'(MAX_COLS)
             + (ADDR_W+REG_W+ROW_W)'(c);
        return full[ADDR_W-1:0];
    endfunction

    // dimension in use: 0 counts as 1, above the limit counts as the limit
    function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                   input int limit);
        logic [REG_W-1:0] res;
        if (v == '0)
            res = REG_W'(1);
        else if (32'(v) > limit)
            res = REG_W'(limit);
        else
            res = v;
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/lba_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module lba_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/lba_walk.sv]
// cell memory, walk stack and the search sequencer that finds the largest group
`default_nettype none

module lba_walk (
    input  wire  logic                      clk,
    input  wire  logic                      rst_n,
    input  wire  lba_pkg::load_req_t        load,
    input  wire  logic                      start,
    input  wire  logic [lba_pkg::REG_W-1:0] rows,
    input  wire  logic [lba_pkg::REG_W-1:0] cols,
    output lba_pkg::walk_res_t              res,
    input  wire  logic                      res_ready
);

    typedef enum logic [9:0] {
        W_IDLE      = 10'b0000000001,
        W_SCAN_RD   = 10'b0000000010,
        W_SCAN_CHK  = 10'b0000000100,
        W_SCAN_NEXT = 10'b0000001000,
        W_POP       = 10'b0000010000,
        W_POP_DATA  = 10'b0000100000,
        W_NB_RD     = 10'b0001000000,
        W_NB_CHK    = 10'b0010000000,
        W_CELL_DONE = 10'b0100000000,
        W_FINISH    = 10'b1000000000
    } walk_state_t;

    walk_state_t state_reg, state_next;

    logic [lba_pkg::ROW_W-1:0]  scan_r_reg, scan_r_next;
    logic [lba_pkg::COL_W-1:0]  scan_c_reg, scan_c_next;
    logic [lba_pkg::ROW_W-1:0]  cur_r_reg, cur_r_next;
    logic [lba_pkg::COL_W-1:0]  cur_c_reg, cur_c_next;
    logic [lba_pkg::ROW_W-1:0]  nb_r_reg, nb_r_next;
    logic [lba_pkg::COL_W-1:0]  nb_c_reg, nb_c_next;
    logic [1:0]                 nb_idx_reg, nb_idx_next;
    logic [lba_pkg::TOP_W-1:0]  top_reg, top_next;
    logic [lba_pkg::AREA_W-1:0] group_reg, group_next;
    logic [lba_pkg::AREA_W-1:0] best_reg, best_next;

    // memory ports
    logic                        cm_we;
    logic [lba_pkg::ADDR_W-1:0]  cm_waddr;
    logic [1:0]                  cm_wdata;
    logic [lba_pkg::ADDR_W-1:0]  cm_raddr;
    logic [1:0]                  cm_rdata;
    logic                        st_we;
    logic [lba_pkg::STK_W-1:0]   st_wdata;
    logic [lba_pkg::TOP_W-1:0]   top_dec;
    logic [lba_pkg::STK_W-1:0]   st_rdata;

    // candidate neighbor of the current cell
    logic                        nb_ok;
    logic [lba_pkg::ROW_W-1:0]   nb_r;
    logic [lba_pkg::COL_W-1:0]   nb_c;
    logic                        scan_last;
    logic                        fresh;

    // cell memory: bit 1 land, bit 0 visited; loading clears visited
    lba_ram #(
        .WIDTH (2),
        .DEPTH (lba_pkg::DEPTH)
    ) u_cell_mem (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    // stack of {row, col} still to expand
    lba_ram #(
        .WIDTH (lba_pkg::STK_W),
        .DEPTH (lba_pkg::DEPTH)
    ) u_stack_mem (
        .clk   (clk),
        .we    (st_we),
        .waddr (top_reg[lba_pkg::ADDR_W-1:0]),
        .wdata (st_wdata),
        .raddr (top_dec[lba_pkg::ADDR_W-1:0]),
        .rdata (st_rdata)
    );

    assign top_dec   = top_reg - lba_pkg::TOP_W'(1);
    assign fresh     = cm_rdata[1] & ~cm_rdata[0];
    assign scan_last = (lba_pkg::REG_W'(scan_r_reg) == rows - lba_pkg::REG_W'(1)) &&
                       (lba_pkg::REG_W'(scan_c_reg) == cols - lba_pkg::REG_W'(1));

    // neighbor select: down, up, right, left
    always_comb
    begin
        nb_ok = 1'b0;
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        case (nb_idx_reg)
            2'd0:
            begin
                nb_ok = (lba_pkg::REG_W'(cur_r_reg) + lba_pkg::REG_W'(1)) < rows;
                nb_r  = cur_r_reg + lba_pkg::ROW_W'(1);
            end
            2'd1:
            begin
                nb_ok = (cur_r_reg != '0);
                nb_r  = cur_r_reg - lba_pkg::ROW_W'(1);
            end
            2'd2:
            begin
                nb_ok = (lba_pkg::REG_W'(cur_c_reg) + lba_pkg::REG_W'(1)) < cols;
                nb_c  = cur_c_reg + lba_pkg::COL_W'(1);
            end
            default:
            begin
                nb_ok = (cur_c_reg != '0);
                nb_c  = cur_c_reg - lba_pkg::COL_W'(1);
            end
        endcase
    end

    // cell memory read address
    always_comb
    begin
        if (state_reg == W_NB_RD)
            cm_raddr = lba_pkg::cell_addr(nb_r, nb_c);
        else
            cm_raddr = lba_pkg::cell_addr(scan_r_reg, scan_c_reg);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        scan_r_next = scan_r_reg;
        scan_c_next = scan_c_reg;
        cur_r_next  = cur_r_reg;
        cur_c_next  = cur_c_reg;
        nb_r_next   = nb_r_reg;
        nb_c_next   = nb_c_reg;
        nb_idx_next = nb_idx_reg;
        top_next    = top_reg;
        group_next  = group_reg;
        best_next   = best_reg;
        cm_we       = load.we;
        cm_waddr    = lba_pkg::cell_addr(load.row, load.col);
        cm_wdata    = {load.land, 1'b0};
        st_we       = 1'b0;
        st_wdata    = {scan_r_reg, scan_c_reg};

        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    scan_r_next = '0;
                    scan_c_next = '0;
                    best_next   = '0;
                    group_next  = '0;
                    top_next    = '0;
                    state_next  = W_SCAN_RD;
                end
            end
            W_SCAN_RD:
            begin
                state_next = W_SCAN_CHK;
            end
            W_SCAN_CHK:
            begin
                if (fresh)
                begin
                    // new group: mark the seed and push it
                    cm_we      = 1'b1;
                    cm_waddr   = lba_pkg::cell_addr(scan_r_reg, scan_c_reg);
                    cm_wdata   = 2'b11;
                    st_we      = 1'b1;
                    st_wdata   = {scan_r_reg, scan_c_reg};
                    top_next   = top_reg + lba_pkg::TOP_W'(1);
                    group_next = lba_pkg::AREA_W'(1);
                    state_next = W_POP;
                end
                else
                begin
                    state_next = W_SCAN_NEXT;
                end
            end
            W_SCAN_NEXT:
            begin
                if (scan_last)
                begin
                    state_next = W_FINISH;
                end
                else
                begin
                    if (lba_pkg::REG_W'(scan_c_reg) == cols - lba_pkg::REG_W'(1))
                    begin
                        scan_c_next = '0;
                        scan_r_next = scan_r_reg + lba_pkg::ROW_W'(1);
                    end
                    else
                    begin
                        scan_c_next = scan_c_reg + lba_pkg::COL_W'(1);
                    end
                    state_next = W_SCAN_RD;
                end
            end
            W_POP:
            begin
                top_next   = top_dec;
                state_next = W_POP_DATA;
            end
            W_POP_DATA:
            begin
                cur_r_next  = st_rdata[lba_pkg::STK_W-1:lba_pkg::COL_W];
                cur_c_next  = st_rdata[lba_pkg::COL_W-1:0];
                nb_idx_next = 2'd0;
                state_next  = W_NB_RD;
            end
            W_NB_RD:
            begin
                nb_r_next = nb_r;
                nb_c_next = nb_c;
                if (nb_ok)
                begin
                    state_next = W_NB_CHK;
                end
                else
                begin
                    nb_idx_next = nb_idx_reg + 2'd1;
                    state_next  = (nb_idx_reg == 2'd3) ? W_CELL_DONE : W_NB_RD;
                end
            end
            W_NB_CHK:
            begin
                if (fresh)
                begin
                    cm_we      = 1'b1;
                    cm_waddr   = lba_pkg::cell_addr(nb_r_reg, nb_c_reg);
                    cm_wdata   = 2'b11;
                    st_we      = 1'b1;
                    st_wdata   = {nb_r_reg, nb_c_reg};
                    top_next   = top_reg + lba_pkg::TOP_W'(1);
                    group_next = (group_reg == lba_pkg::AREA_MAX) ? group_reg
                               : group_reg + lba_pkg::AREA_W'(1);
                end
                nb_idx_next = nb_idx_reg + 2'd1;
                state_next  = (nb_idx_reg == 2'd3) ? W_CELL_DONE : W_NB_RD;
            end
            W_CELL_DONE:
            begin
                if (top_reg == '0)
                begin
                    if (group_reg > best_reg)
                        best_next = group_reg;
                    state_next = W_SCAN_NEXT;
                end
                else
                begin
                    state_next = W_POP;
                end
            end
            W_FINISH:
            begin
                if (res_ready)
                    state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    assign res.valid = (state_reg == W_FINISH);
    assign res.area  = best_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            top_reg   <= '0;
            group_reg <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            group_reg <= group_next;
            best_reg  <= best_next;
        end
    end

    // walk positions
    always_ff @(posedge clk)
    begin
        scan_r_reg <= scan_r_next;
        scan_c_reg <= scan_c_next;
        cur_r_reg  <= cur_r_next;
        cur_c_reg  <= cur_c_next;
        nb_r_reg   <= nb_r_next;
        nb_c_reg   <= nb_c_next;
        nb_idx_reg <= nb_idx_next;
    end

endmodule

`default_nettype wire

[rtl/largest_blob_area.sv]
// top level: register port, cell loader, search engine and result register
`default_nettype none

// Largest blob area. Cells of a binary image arrive in raster order, one per
// beat, and are taken at one per cycle into a cell memory. The beat that
// completes a frame (row_count x col_count, each clamped to 1..64) starts the
// search and in_ready stays low until the result has moved to the output
// register. The search scans every cell once and expands every set cell
// through a stack memory, reading the cell memory through its single read
// port once per in-range neighbor. One beat on out gives max_area, the size
// of the largest 4-connected group, 0 when no cell is set. Loading rewrites
// the visited marks, so no clearing pass is needed. Writing either register
// restarts loading at cell 0.
module largest_blob_area (
    input  wire  logic                       clk,
    input  wire  logic                       rst_n,
    // cell input
    input  wire  logic                       in_valid,
    output logic                             in_ready,
    input  wire  logic                       cell_is_land,
    // result output
    output logic                             out_valid,
    input  wire  logic                       out_ready,
    output logic [lba_pkg::AREA_W-1:0]       max_area,
    // register port
    input  wire  logic                       psel,
    input  wire  logic                       penable,
    input  wire  logic                       pwrite,
    input  wire  logic [2:0]                 paddr,
    input  wire  logic [31:0]                pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [lba_pkg::REG_W-1:0]  row_count_reg, row_count_next;
    logic [lba_pkg::REG_W-1:0]  col_count_reg, col_count_next;
    logic [lba_pkg::ROW_W-1:0]  load_row_reg, load_row_next;
    logic [lba_pkg::COL_W-1:0]  load_col_reg, load_col_next;
    logic                       busy_reg, busy_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lba_pkg::AREA_W-1:0] max_area_reg, max_area_next;

    logic [lba_pkg::REG_W-1:0]  rows;
    logic [lba_pkg::REG_W-1:0]  cols;
    logic                       cfg_write;
    logic                       in_accept;
    logic                       last_cell;
    logic                       last_col;
    logic                       res_ready;
    lba_pkg::load_req_t         load;
    lba_pkg::walk_res_t         res;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                lba_pkg::REG_ROW_COUNT: row_count_next = pwdata[lba_pkg::REG_W-1:0];
                lba_pkg::REG_COL_COUNT: col_count_next = pwdata[lba_pkg::REG_W-1:0];
                default:                row_count_next = row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lba_pkg::REG_ROW_COUNT: prdata = 32'(row_count_reg);
            lba_pkg::REG_COL_COUNT: prdata = 32'(col_count_reg);
            default:                prdata = '0;
        endcase
    end

    // dimensions in use
    assign rows = lba_pkg::clamp_dim(row_count_reg, lba_pkg::MAX_ROWS);
    assign cols = lba_pkg::clamp_dim(col_count_reg, lba_pkg::MAX_COLS);

    // cell loader
    assign in_ready  = ~busy_reg;
    assign in_accept = in_valid & in_ready;
    assign last_col  = (lba_pkg::REG_W'(load_col_reg) == cols - lba_pkg::REG_W'(1));
    assign last_cell = last_col &&
                       (lba_pkg::REG_W'(load_row_reg) == rows - lba_pkg::REG_W'(1));

    assign load.we   = in_accept;
    assign load.row  = load_row_reg;
    assign load.col  = load_col_reg;
    assign load.land = cell_is_land;

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        if (cfg_write)
        begin
            load_row_next = '0;
            load_col_next = '0;
        end
        else if (in_accept)
        begin
            if (last_cell)
            begin
                load_row_next = '0;
                load_col_next = '0;
            end
            else if (last_col)
            begin
                load_col_next = '0;
                load_row_next = load_row_reg + lba_pkg::ROW_W'(1);
            end
            else
            begin
                load_col_next = load_col_reg + lba_pkg::COL_W'(1);
            end
        end
    end

    // search engine
    lba_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .start     (in_accept & last_cell),
        .rows      (rows),
        .cols      (cols),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register, free once the previous beat has gone
    assign res_ready = ~out_valid_reg | out_ready;

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        max_area_next  = max_area_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            max_area_next  = res.area;
            busy_next      = 1'b0;
        end
        if (in_accept && last_cell)
            busy_next = 1'b1;
    end

    assign out_valid = out_valid_reg;
    assign max_area  = max_area_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= lba_pkg::REG_W'(lba_pkg::MAX_ROWS);
            col_count_reg <= lba_pkg::REG_W'(lba_pkg::MAX_COLS);
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        max_area_reg <= max_area_next;
    end

endmodule

`default_nettype wire
